// ===== src/rdq_pkg.sv =====
// Package for the reversible deque: sizes, word types, opcodes, control structs, ring math.
`default_nettype none
package rdq_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 11;

  typedef enum logic [1:0] {
    OP_PUSH_HEAD = 2'd0,
    OP_PUSH_TAIL = 2'd1,
    OP_POP_HEAD  = 2'd2,
    OP_REVERSE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] value_out;
    logic [COUNT_W-1:0]       count;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic read_pending;
  } dp_status_t;

  // Step off places around the ring, upward or downward; off is at most CAPACITY.
  function automatic logic [IDX_W-1:0] ring_move(input logic [IDX_W-1:0] pos,
                                                 input logic [CNT_W-1:0] off,
                                                 input logic up);
    logic [CNT_W:0] cap;
    logic [CNT_W:0] sum;
    cap = (CNT_W + 1)'(CAPACITY);
    if (up) begin
      sum = (CNT_W + 1)'(pos) + (CNT_W + 1)'(off);
    end else begin
      sum = (CNT_W + 1)'(pos) + cap - (CNT_W + 1)'(off);
    end
    if (sum >= cap) begin
      sum = sum - cap;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/rdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/rdq_ctrl.sv =====
// Controller FSM: sequences word intake, execution, RAM read and result hand-off.
`default_nettype none
module rdq_ctrl
  import rdq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    rsp_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.read_pending ? S_READ : S_OUT;
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) begin
          // result leaves this cycle, so the next word may come in alongside
          req_stall = 1'b0;
          if (req_valid) begin
            cmd.load   = 1'b1;
            state_next = S_EXEC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.exec)
    else $error("load not followed by execute");

  a_capture_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> ($past(cmd.exec) && $past(status.read_pending)))
    else $error("capture without a pending RAM read");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.capture) |-> !cmd.load)
    else $error("new word loaded while one is in flight");

endmodule
`default_nettype wire

// ===== src/rdq_datapath.sv =====
// Datapath: front ring pointer, entry count, direction flag, entry RAM and result register.
`default_nettype none
module rdq_datapath
  import rdq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ctrl_cmd_t cmd,
  input  wire req_t      req,
  output dp_status_t     status,
  output rsp_t           rsp
);

  req_t             req_q;
  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] front_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             rev;
  logic             rev_next;
  logic             ok_next;

  logic             empty;
  logic             full;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_rdata;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(CAPACITY));
  assign status.read_pending = (req_q.op == OP_POP_HEAD) && !empty;

  // Moving toward the tail goes upward unless the order is reversed.
  always_comb begin
    front_next = front;
    count_next = count;
    rev_next   = rev;
    ok_next    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ring_move(front, count, !rev);
    case (req_q.op)
      OP_PUSH_HEAD: begin
        if (!full) begin
          front_next = ring_move(front, CNT_W'(1), rev);
          mem_waddr  = front_next;
          mem_we     = 1'b1;
          count_next = count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      OP_PUSH_TAIL: begin
        if (!full) begin
          mem_we     = 1'b1;
          count_next = count + CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      OP_POP_HEAD: begin
        if (!empty) begin
          front_next = ring_move(front, CNT_W'(1), !rev);
          count_next = count - CNT_W'(1);
          ok_next    = 1'b1;
        end
      end
      OP_REVERSE: begin
        ok_next = 1'b1;
        if (count > CNT_W'(1)) begin
          front_next = ring_move(front, count - CNT_W'(1), !rev);
          rev_next   = !rev;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (cmd.exec) begin
      front <= front_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      rsp.ok        <= ok_next;
      rsp.value_out <= '0;
      rsp.count     <= COUNT_W'(count_next);
    end else if (cmd.capture) begin
      rsp.value_out <= mem_rdata;
    end
  end

  rdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && mem_we),
    .waddr (mem_waddr),
    .wdata (req_q.value_in),
    .re    (cmd.exec),
    .raddr (front),
    .rdata (mem_rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_state_only_on_exec: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.exec)) |-> ($stable(count) && $stable(front) && $stable(rev)))
    else $error("queue state changed outside execute");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && !ok_next) |=> $stable(count))
    else $error("failed operation changed the count");

endmodule
`default_nettype wire

// ===== src/reversible_deque_unit.sv =====
// Reversible deque top level: a word moves from the request side to the result register.
// Sequence: a request is loaded, executed, then (for a remove that reads the RAM) read, then output.
// The unit holds one word at a time: it takes no new request before the last result leaves;
// the next request is taken in the cycle the previous result is taken.
// The registered-read entry RAM adds the read state on a remove.
// Reset (rst, synchronous): empties the queue, clears direction; RAM contents are kept.
`default_nettype none
module reversible_deque_unit
  import rdq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rdq_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .rsp    (rsp)
  );

endmodule
`default_nettype wire

// ===== test/reversible_deque_unit_tb.sv =====
// Self-checking testbench for reversible_deque_unit: random and directed deque operations.
`default_nettype none
module reversible_deque_unit_tb;
  import rdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_PCT   = 18;
  localparam int QUIET_LIMIT = 4000;

  class deque_scoreboard;
    logic signed [DATA_W-1:0] slots [CAPACITY];
    int unsigned head_pos;
    int unsigned held;
    bit          flipped;
    rsp_t        results_due[$];
    int          mismatches;

    // flipped swaps which way "toward the tail" points in the ring
    function int unsigned ring_step(int unsigned pos, int unsigned off, bit toward_tail);
      if (toward_tail ^ flipped) return (pos + off) % CAPACITY;
      return (pos + CAPACITY - off % CAPACITY) % CAPACITY;
    endfunction

    function void note_word(req_t w);
      rsp_t e;
      e = '0;
      case (w.op)
        OP_PUSH_HEAD: begin
          if (held < CAPACITY) begin
            head_pos = ring_step(head_pos, 1, 1'b0);
            slots[head_pos] = w.value_in;
            held++;
            e.ok = 1'b1;
          end
        end
        OP_PUSH_TAIL: begin
          if (held < CAPACITY) begin
            slots[ring_step(head_pos, held, 1'b1)] = w.value_in;
            held++;
            e.ok = 1'b1;
          end
        end
        OP_POP_HEAD: begin
          if (held > 0) begin
            e.value_out = slots[head_pos];
            head_pos = ring_step(head_pos, 1, 1'b1);
            held--;
            e.ok = 1'b1;
          end
        end
        default: begin
          // head jumps to the old tail, then direction flips
          if (held > 1) begin
            head_pos = ring_step(head_pos, held - 1, 1'b1);
            flipped = !flipped;
          end
          e.ok = 1'b1;
        end
      endcase
      e.count = COUNT_W'(held);
      results_due.push_back(e);
    endfunction

    function void check_word(rsp_t got);
      rsp_t e;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: ok=%0b value_out=%0d count=%0d",
                   got.ok, got.value_out, got.count);
        return;
      end
      e = results_due.pop_front();
      if (got.ok !== e.ok || got.value_out !== e.value_out || got.count !== e.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected ok=%0b value_out=%0d count=%0d,",
                    " got ok=%0b value_out=%0d count=%0d"},
                   e.ok, e.value_out, e.count, got.ok, got.value_out, got.count);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  deque_scoreboard sb;
  bit calm;
  int quiet_cycles;

  reversible_deque_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_word(rsp);
    end
    rsp_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("reversible_deque_unit_tb failed");
        $finish;
      end
    end
  end

  function automatic op_t pick_op(int w_head, int w_tail, int w_pop);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_head) return OP_PUSH_HEAD;
    if (r < w_head + w_tail) return OP_PUSH_TAIL;
    if (r < w_head + w_tail + w_pop) return OP_POP_HEAD;
    return OP_REVERSE;
  endfunction

  task automatic send_word(input op_t op, input logic signed [DATA_W-1:0] value);
    req_t w;
    w.op = op;
    w.value_in = value;
    if (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.note_word(w);
  endtask

  task automatic wait_all_results();
    req_valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    rsp_stall <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty cases, single-entry reverse, extreme and alternating values
    send_word(OP_POP_HEAD, 32'sh7FFF_FFFF);
    send_word(OP_REVERSE, -1);
    send_word(OP_PUSH_HEAD, 32'sh7FFF_FFFF);
    send_word(OP_REVERSE, 0);
    send_word(OP_POP_HEAD, 0);
    send_word(OP_PUSH_TAIL, 32'sh8000_0000);
    send_word(OP_PUSH_TAIL, 0);
    send_word(OP_PUSH_HEAD, -1);
    send_word(OP_PUSH_TAIL, 32'sh5555_5555);
    send_word(OP_PUSH_HEAD, 32'shAAAA_AAAA);
    send_word(OP_REVERSE, 32'sh1234_5678);
    send_word(OP_POP_HEAD, -1);
    send_word(OP_PUSH_HEAD, 1);
    send_word(OP_REVERSE, 0);
    send_word(OP_PUSH_TAIL, 32'sh0F0F_0F0F);
    repeat (6) send_word(OP_POP_HEAD, 0);
    send_word(OP_REVERSE, 0);

    // mixed traffic at low occupancy
    repeat (80) send_word(pick_op(30, 30, 30), $urandom());
    wait_all_results();

    // fill to capacity with no idling on either side, then push against full
    calm = 1'b1;
    while (sb.held < CAPACITY) send_word(pick_op(48, 48, 0), $urandom());
    repeat (12) send_word(pick_op(30, 30, 20), $urandom());
    calm = 1'b0;

    // pull part of the contents back out
    repeat (30) send_word(pick_op(3, 3, 88), $urandom());

    wait_all_results();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("reversible_deque_unit_tb passed");
    end else begin
      $display("reversible_deque_unit_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/rdq_pkg.sv
src/rdq_ram.sv
src/rdq_ctrl.sv
src/rdq_datapath.sv
src/reversible_deque_unit.sv
test/reversible_deque_unit_tb.sv
